// ----- sv/uidfs_pkg.sv -----
// shared types and constants of the user id field splitter
`timescale 1ns / 1ps

package uidfs_pkg;

  localparam int unsigned MAX_LEN_DEF = 256;
  localparam int unsigned POS_OUT_W   = 9;
  localparam int unsigned DEPTH_W     = 8;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;
  localparam int unsigned OQ_DEPTH    = 4;
  localparam int unsigned OQ_AW       = $clog2(OQ_DEPTH);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_EMAIL   = 2'd1;
  localparam logic [1:0] KIND_COMMENT = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  typedef struct packed {
    logic [1:0]           field_kind;
    logic [POS_OUT_W-1:0] start_pos;
    logic [POS_OUT_W-1:0] end_pos;
    logic                 found_any;
    logic                 last_out;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ----- sv/uidfs_if.sv -----
// handshake interfaces for the input byte channel and the result channel
`timescale 1ns / 1ps

interface uidfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_last;

  modport source (output valid, output ch, output is_last, input ready);
  modport sink (input valid, input ch, input is_last, output ready);
endinterface

interface uidfs_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          field_kind;
  logic [uidfs_pkg::POS_OUT_W-1:0]     start_pos;
  logic [uidfs_pkg::POS_OUT_W-1:0]     end_pos;
  logic                                found_any;
  logic                                last_out;

  modport source (output valid, output field_kind, output start_pos, output end_pos,
                  output found_any, output last_out, input ready);
  modport sink (input valid, input field_kind, input start_pos, input end_pos,
                input found_any, input last_out, output ready);
endinterface

// ----- sv/uidfs_core.sv -----
// input register, parse state and per-byte field detection
`timescale 1ns / 1ps

module uidfs_core #(
  parameter int unsigned MAX_LEN = uidfs_pkg::MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  uidfs_in_if.sink         in_ch,
  input  logic             room,
  output uidfs_pkg::push_t push
);

  localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  logic                          ireg_v_r;
  logic [7:0]                    ch_r;
  logic                          last_r;
  logic                          adv;

  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [POS_W-1:0]              seg_r, seg_nxt;
  logic [uidfs_pkg::DEPTH_W-1:0] ad_r, ad_nxt;
  logic [uidfs_pkg::DEPTH_W-1:0] pd_r, pd_nxt;
  logic                          in_name_r, in_name_nxt;
  logic                          name_f_r, name_f_nxt;
  logic                          email_f_r, email_f_nxt;
  logic                          cmt_f_r, cmt_f_nxt;

  uidfs_pkg::result_t            f_res, n_res, s_res;
  logic                          f_v, n_v, s_v;
  uidfs_pkg::push_t              push_c;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    sat_inc = (v >= POS_MAX) ? POS_MAX : v + 1'b1;
  endfunction

  assign adv         = ireg_v_r && room;
  assign in_ch.ready = !ireg_v_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ireg_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      ireg_v_r <= 1'b1;
    end else if (adv) begin
      ireg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ch_r   <= in_ch.ch;
      last_r <= in_ch.is_last;
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    seg_nxt     = seg_r;
    ad_nxt      = ad_r;
    pd_nxt      = pd_r;
    in_name_nxt = in_name_r;
    name_f_nxt  = name_f_r;
    email_f_nxt = email_f_r;
    cmt_f_nxt   = cmt_f_r;
    f_v         = 1'b0;
    n_v         = 1'b0;
    s_v         = 1'b0;
    f_res       = '0;
    n_res       = '0;
    s_res       = '0;

    if (ad_r != '0) begin
      if (ch_r == uidfs_pkg::CH_LT) begin
        if (ad_r < uidfs_pkg::DEPTH_MAX) ad_nxt = ad_r + 1'b1;
      end else if (ch_r == uidfs_pkg::CH_GT) begin
        ad_nxt = ad_r - 1'b1;
        if (ad_nxt == '0 && !email_f_r) begin
          f_v              = 1'b1;
          f_res.field_kind = uidfs_pkg::KIND_EMAIL;
          f_res.start_pos  = uidfs_pkg::POS_OUT_W'(seg_r);
          f_res.end_pos    = uidfs_pkg::POS_OUT_W'(pos_r);
          email_f_nxt      = 1'b1;
          seg_nxt          = sat_inc(pos_r);
        end
      end
    end else if (pd_r != '0) begin
      if (ch_r == uidfs_pkg::CH_LPAR) begin
        if (pd_r < uidfs_pkg::DEPTH_MAX) pd_nxt = pd_r + 1'b1;
      end else if (ch_r == uidfs_pkg::CH_RPAR) begin
        pd_nxt = pd_r - 1'b1;
        if (pd_nxt == '0 && !cmt_f_r) begin
          f_v              = 1'b1;
          f_res.field_kind = uidfs_pkg::KIND_COMMENT;
          f_res.start_pos  = uidfs_pkg::POS_OUT_W'(seg_r);
          f_res.end_pos    = uidfs_pkg::POS_OUT_W'(pos_r);
          cmt_f_nxt        = 1'b1;
          seg_nxt          = sat_inc(pos_r);
        end
      end
    end else if (ch_r == uidfs_pkg::CH_LT || ch_r == uidfs_pkg::CH_LPAR) begin
      if (in_name_r) begin
        if (!name_f_r) begin
          f_v              = 1'b1;
          f_res.field_kind = uidfs_pkg::KIND_NAME;
          f_res.start_pos  = uidfs_pkg::POS_OUT_W'(seg_r);
          f_res.end_pos    = uidfs_pkg::POS_OUT_W'(pos_r);
          name_f_nxt       = 1'b1;
          seg_nxt          = sat_inc(pos_r);
        end
        in_name_nxt = 1'b0;
      end else if (ch_r == uidfs_pkg::CH_LT) begin
        seg_nxt = sat_inc(pos_r);
      end
      if (ch_r == uidfs_pkg::CH_LT) begin
        ad_nxt = uidfs_pkg::DEPTH_W'(1);
      end else begin
        pd_nxt = uidfs_pkg::DEPTH_W'(1);
      end
    end else if (!in_name_r && ch_r != uidfs_pkg::CH_SPACE && ch_r != uidfs_pkg::CH_TAB) begin
      in_name_nxt = 1'b1;
    end

    pos_nxt = sat_inc(pos_r);

    if (last_r) begin
      if (in_name_nxt && !name_f_nxt) begin
        n_v              = 1'b1;
        n_res.field_kind = uidfs_pkg::KIND_NAME;
        n_res.start_pos  = uidfs_pkg::POS_OUT_W'(seg_nxt);
        n_res.end_pos    = uidfs_pkg::POS_OUT_W'(pos_nxt);
      end
      s_v              = 1'b1;
      s_res.field_kind = uidfs_pkg::KIND_SUMMARY;
      s_res.found_any  = name_f_nxt || n_v || email_f_nxt || cmt_f_nxt;
      s_res.last_out   = 1'b1;
      pos_nxt          = '0;
      seg_nxt          = '0;
      ad_nxt           = '0;
      pd_nxt           = '0;
      in_name_nxt      = 1'b0;
      name_f_nxt       = 1'b0;
      email_f_nxt      = 1'b0;
      cmt_f_nxt        = 1'b0;
    end
  end

  // pack up to two results into the queue slots, in model order
  always_comb begin
    push_c = '0;
    if (f_v) begin
      push_c.r0  = f_res;
      push_c.r1  = n_v ? n_res : s_res;
      push_c.cnt = (n_v || s_v) ? 2'd2 : 2'd1;
    end else if (n_v) begin
      push_c.r0  = n_res;
      push_c.r1  = s_res;
      push_c.cnt = s_v ? 2'd2 : 2'd1;
    end else begin
      push_c.r0  = s_res;
      push_c.r1  = s_res;
      push_c.cnt = s_v ? 2'd1 : 2'd0;
    end
    if (!adv) push_c.cnt = 2'd0;
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      seg_r     <= '0;
      ad_r      <= '0;
      pd_r      <= '0;
      in_name_r <= 1'b0;
      name_f_r  <= 1'b0;
      email_f_r <= 1'b0;
      cmt_f_r   <= 1'b0;
    end else if (adv) begin
      pos_r     <= pos_nxt;
      seg_r     <= seg_nxt;
      ad_r      <= ad_nxt;
      pd_r      <= pd_nxt;
      in_name_r <= in_name_nxt;
      name_f_r  <= name_f_nxt;
      email_f_r <= email_f_nxt;
      cmt_f_r   <= cmt_f_nxt;
    end
  end

endmodule

// ----- sv/uidfs_oq.sv -----
// result queue taking up to two items per cycle and giving one while out_ch is ready
`timescale 1ns / 1ps

module uidfs_oq (
  input  logic             clk,
  input  logic             rst_n,
  input  uidfs_pkg::push_t push,
  output logic             room,
  uidfs_out_if.source      out_ch
);

  localparam int unsigned CNT_W = uidfs_pkg::OQ_AW + 1;

  uidfs_pkg::result_t            mem_r [uidfs_pkg::OQ_DEPTH];
  logic [uidfs_pkg::OQ_AW-1:0]   wp_r, wp_nxt;
  logic [uidfs_pkg::OQ_AW-1:0]   rp_r, rp_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          pop;
  uidfs_pkg::result_t            head;

  assign room = cnt_r <= CNT_W'(uidfs_pkg::OQ_DEPTH - 2);
  assign pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    wp_nxt  = wp_r + uidfs_pkg::OQ_AW'(push.cnt);
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wp_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[wp_r + 1'b1] <= push.r1;
  end

  assign head              = mem_r[rp_r];
  assign out_ch.valid      = cnt_r != '0;
  assign out_ch.field_kind = head.field_kind;
  assign out_ch.start_pos  = head.start_pos;
  assign out_ch.end_pos    = head.end_pos;
  assign out_ch.found_any  = head.found_any;
  assign out_ch.last_out   = head.last_out;

endmodule

// ----- sv/user_id_field_splitter.sv -----
// top level of the user id field splitter
//
// in_ch carries one byte of a user id string per item, with is_last on its
// final byte. out_ch carries the fields found: kind, start and end position,
// and on the final byte a summary item with last_out set and found_any.
// An accepted byte is held in the input register; when it advances, its
// results are written into a four-entry result queue and appear on out_ch
// from the queue. One byte is taken every cycle while the queue has room
// for two results; a byte that yields two results (a field plus the
// summary) writes both at once and the queue gives them out one by one.
// The input register advances only while the queue has space for two
// results, so a stalled receiver backs up into in_ch.ready after the
// queue fills; nothing is dropped. Reset clears the parse state,
// the input register and the queue; the block takes a byte in the first
// cycle after reset. Parse state also returns to its reset value after each
// final byte.
`timescale 1ns / 1ps

module user_id_field_splitter #(
  parameter int unsigned MAX_LEN = uidfs_pkg::MAX_LEN_DEF
) (
  input logic         clk,
  input logic         rst_n,
  uidfs_in_if.sink    in_ch,
  uidfs_out_if.source out_ch
);

  uidfs_pkg::push_t push;
  logic             room;

  uidfs_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  uidfs_oq u_oq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

// ----- sv/uidfs_checker.sv -----
// port checker for the user id field splitter and its bind
`timescale 1ns / 1ps

module uidfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] field_kind,
  input logic [8:0] start_pos,
  input logic [8:0] end_pos,
  input logic       found_any,
  input logic       last_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(field_kind) && $stable(start_pos)
      && $stable(end_pos) && $stable(found_any) && $stable(last_out))
    else $error("stalled result item changed");

  a_summary_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && field_kind == uidfs_pkg::KIND_SUMMARY |-> last_out
      && start_pos == '0 && end_pos == '0)
    else $error("summary item malformed");

  a_field_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && field_kind != uidfs_pkg::KIND_SUMMARY |-> !last_out && !found_any)
    else $error("field item carries summary flags");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item right after reset");

endmodule

bind user_id_field_splitter uidfs_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .field_kind (out_ch.field_kind),
  .start_pos  (out_ch.start_pos),
  .end_pos    (out_ch.end_pos),
  .found_any  (out_ch.found_any),
  .last_out   (out_ch.last_out)
);

// ----- dv/user_id_field_splitter_tb.sv -----
// self-checking testbench for the user id field splitter
`timescale 1ns / 1ps

module user_id_field_splitter_tb;

  localparam logic [8:0] LEN_CAP = 9'(uidfs_pkg::MAX_LEN_DEF);
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TIMEOUT_NS = 2_000_000;

  logic clk;
  logic rst_n;

  uidfs_in_if  in_if ();
  uidfs_out_if out_if ();

  user_id_field_splitter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // mirrored parse state
  logic [8:0] cur_pos;
  logic [8:0] seg_start;
  logic [7:0] angle_lvl;
  logic [7:0] paren_lvl;
  logic       in_name;
  logic       name_seen;
  logic       email_seen;
  logic       comment_seen;

  uidfs_pkg::result_t fields_due[$];
  logic [7:0]         uid_q[$];
  uidfs_pkg::result_t seen_field;
  uidfs_pkg::result_t due_field;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned bytes_sent;
  int unsigned strings_sent;
  int unsigned fields_checked;
  int unsigned mismatches;
  logic        hold_req;
  logic        hold_on;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [8:0] pos_step(input logic [8:0] v);
    return (v >= LEN_CAP) ? LEN_CAP : v + 9'd1;
  endfunction

  function automatic void clear_parse();
    cur_pos      = '0;
    seg_start    = '0;
    angle_lvl    = '0;
    paren_lvl    = '0;
    in_name      = 1'b0;
    name_seen    = 1'b0;
    email_seen   = 1'b0;
    comment_seen = 1'b0;
  endfunction

  function automatic void log_field(input logic [1:0] kind, input logic [8:0] s,
                                    input logic [8:0] e, input logic any, input logic fin);
    uidfs_pkg::result_t r;
    r.field_kind = kind;
    r.start_pos  = s;
    r.end_pos    = e;
    r.found_any  = any;
    r.last_out   = fin;
    fields_due.push_back(r);
  endfunction

  // a name run is closed by an opening bracket at position p
  function automatic void end_name_run(input logic [8:0] p);
    if (in_name) begin
      if (!name_seen) begin
        log_field(uidfs_pkg::KIND_NAME, seg_start, p, 1'b0, 1'b0);
        name_seen = 1'b1;
        seg_start = pos_step(p);
      end
      in_name = 1'b0;
    end
  endfunction

  function automatic void predict_fields(input logic [7:0] c, input logic lst);
    logic [8:0] p;
    logic       any;
    p = cur_pos;
    if (angle_lvl != 0) begin
      if (c == uidfs_pkg::CH_LT) begin
        if (angle_lvl < uidfs_pkg::DEPTH_MAX) angle_lvl = angle_lvl + 8'd1;
      end else if (c == uidfs_pkg::CH_GT) begin
        angle_lvl = angle_lvl - 8'd1;
        if (angle_lvl == 0 && !email_seen) begin
          log_field(uidfs_pkg::KIND_EMAIL, seg_start, p, 1'b0, 1'b0);
          email_seen = 1'b1;
          seg_start  = pos_step(p);
        end
      end
    end else if (paren_lvl != 0) begin
      if (c == uidfs_pkg::CH_LPAR) begin
        if (paren_lvl < uidfs_pkg::DEPTH_MAX) paren_lvl = paren_lvl + 8'd1;
      end else if (c == uidfs_pkg::CH_RPAR) begin
        paren_lvl = paren_lvl - 8'd1;
        if (paren_lvl == 0 && !comment_seen) begin
          log_field(uidfs_pkg::KIND_COMMENT, seg_start, p, 1'b0, 1'b0);
          comment_seen = 1'b1;
          seg_start    = pos_step(p);
        end
      end
    end else if (c == uidfs_pkg::CH_LT) begin
      if (in_name) end_name_run(p);
      else seg_start = pos_step(p);
      angle_lvl = 8'd1;
    end else if (c == uidfs_pkg::CH_LPAR) begin
      end_name_run(p);
      paren_lvl = 8'd1;
    end else if (!in_name && c != uidfs_pkg::CH_SPACE && c != uidfs_pkg::CH_TAB) begin
      in_name = 1'b1;
    end
    cur_pos = pos_step(p);
    if (lst) begin
      if (in_name && !name_seen) begin
        log_field(uidfs_pkg::KIND_NAME, seg_start, cur_pos, 1'b0, 1'b0);
        name_seen = 1'b1;
      end
      any = name_seen | email_seen | comment_seen;
      log_field(uidfs_pkg::KIND_SUMMARY, '0, '0, any, 1'b1);
      clear_parse();
    end
  endfunction

  function automatic logic [7:0] pick_byte(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom_range(1, 255)); while (v == a || v == b);
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.ch      <= c;
    in_if.is_last <= lst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_fields(c, lst);
    bytes_sent++;
  endtask

  task automatic send_uid();
    foreach (uid_q[i]) send_byte(uid_q[i], i == uid_q.size() - 1);
    strings_sent++;
  endtask

  task automatic load_text(input string s);
    uid_q.delete();
    for (int i = 0; i < s.len(); i++) uid_q.push_back(s[i]);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_blanks(input int unsigned n);
    repeat (n) uid_q.push_back($urandom_range(1) ? uidfs_pkg::CH_SPACE : uidfs_pkg::CH_TAB);
  endtask

  // bracketed part with random content, sometimes one nested level
  task automatic add_group(input logic [7:0] op, input logic [7:0] cl);
    uid_q.push_back(op);
    repeat ($urandom_range(5)) uid_q.push_back(pick_byte(op, cl));
    if ($urandom_range(3) == 0) begin
      uid_q.push_back(op);
      repeat ($urandom_range(3)) uid_q.push_back(pick_byte(op, cl));
      uid_q.push_back(cl);
    end
    uid_q.push_back(cl);
  endtask

  task automatic build_uid();
    int unsigned mode;
    int unsigned keep;
    uid_q.delete();
    mode = $urandom_range(9);
    if (mode < 7) begin
      add_blanks($urandom_range(2));
      repeat ($urandom_range(8)) uid_q.push_back(pick_byte(uidfs_pkg::CH_LT, uidfs_pkg::CH_LPAR));
      add_blanks($urandom_range(2));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(1)) add_group(uidfs_pkg::CH_LPAR, uidfs_pkg::CH_RPAR);
        else add_group(uidfs_pkg::CH_LT, uidfs_pkg::CH_GT);
        add_blanks($urandom_range(1));
      end
      // cut short to leave brackets open
      if (mode == 6) begin
        keep = $urandom_range(1, uid_q.size());
        while (uid_q.size() > keep) void'(uid_q.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(7))
          0:       uid_q.push_back(uidfs_pkg::CH_LT);
          1:       uid_q.push_back(uidfs_pkg::CH_GT);
          2:       uid_q.push_back(uidfs_pkg::CH_LPAR);
          3:       uid_q.push_back(uidfs_pkg::CH_RPAR);
          4:       uid_q.push_back(uidfs_pkg::CH_SPACE);
          5:       uid_q.push_back(uidfs_pkg::CH_TAB);
          default: uid_q.push_back(8'($urandom_range(1, 255)));
        endcase
      end
    end
    if (uid_q.size() == 0) uid_q.push_back(8'h41);
  endtask

  task automatic test_single_bytes();
    uid_q.delete();
    uid_q.push_back(8'hFF);
    send_uid();
    uid_q.delete();
    uid_q.push_back(uidfs_pkg::CH_TAB);
    uid_q.push_back(8'h01);
    send_uid();
    load_text(" ");
    send_uid();
    drain();
  endtask

  task automatic test_field_order();
    load_text("N(c)<e>");
    send_uid();
    load_text("x<");
    send_uid();
    load_text(")>");
    send_uid();
    load_text("<<>>((");
    send_uid();
    drain();
  endtask

  // angle depth pinned at its top, so the parentheses after it stay inside
  task automatic test_deep_nesting();
    uid_q.delete();
    repeat (256) uid_q.push_back(uidfs_pkg::CH_LT);
    uid_q.push_back(uidfs_pkg::CH_LPAR);
    uid_q.push_back(uidfs_pkg::CH_RPAR);
    uid_q.push_back(8'h78);
    send_uid();
    drain();
  endtask

  task automatic test_long_string();
    uid_q.delete();
    uid_q.push_back(8'h4E);
    repeat (256) uid_q.push_back(uidfs_pkg::CH_SPACE);
    uid_q.push_back(uidfs_pkg::CH_LT);
    uid_q.push_back(8'h65);
    uid_q.push_back(uidfs_pkg::CH_GT);
    send_uid();
    drain();
  endtask

  task automatic test_backpressure();
    int unsigned base;
    base = bytes_sent;
    hold_req <= 1'b1;
    while (bytes_sent < base + 40) begin
      build_uid();
      send_uid();
    end
    drain();
  endtask

  task automatic test_random(input int unsigned n);
    int unsigned base;
    base = bytes_sent;
    while (bytes_sent < base + n) begin
      build_uid();
      send_uid();
    end
    drain();
  endtask

  // long receiver hold
  initial begin
    hold_on = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_on  <= 1'b1;
        hold_req <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_if.ready <= !hold_on && ($urandom_range(99) >= snk_idle_pct);
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_field.field_kind = out_if.field_kind;
      seen_field.start_pos  = out_if.start_pos;
      seen_field.end_pos    = out_if.end_pos;
      seen_field.found_any  = out_if.found_any;
      seen_field.last_out   = out_if.last_out;
      fields_checked++;
      if (fields_due.size() == 0) begin
        mismatches++;
        $display("%0t: item with nothing expected: kind %0d start %0d end %0d any %0b last %0b",
                 $time, seen_field.field_kind, seen_field.start_pos, seen_field.end_pos,
                 seen_field.found_any, seen_field.last_out);
      end else begin
        due_field = fields_due.pop_front();
        if (seen_field.field_kind !== due_field.field_kind ||
            seen_field.start_pos !== due_field.start_pos ||
            seen_field.end_pos !== due_field.end_pos ||
            seen_field.found_any !== due_field.found_any ||
            seen_field.last_out !== due_field.last_out) begin
          mismatches++;
          $display("%0t: expected kind %0d start %0d end %0d any %0b last %0b", $time,
                   due_field.field_kind, due_field.start_pos, due_field.end_pos,
                   due_field.found_any, due_field.last_out);
          $display("%0t:   actual kind %0d start %0d end %0d any %0b last %0b", $time,
                   seen_field.field_kind, seen_field.start_pos, seen_field.end_pos,
                   seen_field.found_any, seen_field.last_out);
        end
      end
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.ch      = uidfs_pkg::CH_SPACE;
    in_if.is_last = 1'b0;
    out_if.ready  = 1'b0;
    hold_req      = 1'b0;
    bytes_sent     = 0;
    strings_sent   = 0;
    fields_checked = 0;
    mismatches     = 0;
    clear_parse();
    src_idle_pct = 7;
    snk_idle_pct = 59;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_single_bytes();
    test_field_order();
    test_deep_nesting();
    test_long_string();
    test_backpressure();
    test_random(40);
    src_idle_pct = 59;
    snk_idle_pct = 7;
    test_random(40);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(40);

    $display("run covered %0d strings, %0d bytes and %0d result items", strings_sent,
             bytes_sent, fields_checked);
    $display("directed fields, deep nesting, position saturation, a long hold, random ids");
    if (mismatches == 0 && fields_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
